// ----- design/infix_to_postfix_converter_unit_macros.svh -----
// Assertion macros for the infix to postfix converter.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication
`define I2P_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/i2p_pkg.sv -----
// Package for the infix to postfix converter: beat types, character codes,
// operator precedence. No dependencies.
`default_nettype none

package i2p_pkg;

  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharNul    = 8'h00;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expr;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_out;
    logic       overflow_seen;
  } out_beat_t;

  typedef enum logic [2:0] {
    KIND_SKIP    = 3'd0,
    KIND_LPAREN  = 3'd1,
    KIND_RPAREN  = 3'd2,
    KIND_OPER    = 3'd3,
    KIND_LITERAL = 3'd4
  } i2p_kind_e;

  typedef struct packed {
    i2p_kind_e  kind;
    logic [7:0] ch;
    logic       last;
  } q_item_t;

  function automatic logic [1:0] rank_of(logic [7:0] ch);
    logic [1:0] r;
    case (ch) inside
      CharPlus, CharMinus: r = 2'd1;
      CharStar, CharSlash: r = 2'd2;
      CharCaret:           r = 2'd3;
      default:             r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/i2p_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module i2p_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/i2p_front.sv -----
// Front end: accepts input beats, classifies each character and queues it.
// Depends on i2p_pkg.
`default_nettype none

module i2p_front import i2p_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_beat_t in_data_i,
  output logic          q_valid_o,
  input  wire logic     q_ready_i,
  output q_item_t       q_item_o
);

  q_item_t    slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;
  q_item_t    item;
  logic       push, pop;

  always_comb begin
    item.ch   = in_data_i.in_char;
    item.last = in_data_i.end_of_expr;
    case (in_data_i.in_char) inside
      CharSpace, CharTab:                                item.kind = KIND_SKIP;
      CharLParen:                                        item.kind = KIND_LPAREN;
      CharRParen:                                        item.kind = KIND_RPAREN;
      CharPlus, CharMinus, CharStar, CharSlash, CharCaret: item.kind = KIND_OPER;
      default:                                           item.kind = KIND_LITERAL;
    endcase
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_item_o   = slot_q[rptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      if (push && !pop)      fill_q <= fill_q + 2'd1;
      else if (pop && !push) fill_q <= fill_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

// ----- design/i2p_back.sv -----
// Back end: operator stack sequencer with top-of-stack register, stack RAM
// and output register. Depends on i2p_pkg and i2p_ram.
`default_nettype none

module i2p_back import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  output logic         q_ready_o,
  input  wire q_item_t q_item_i,
  output logic         busy_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_beat_t    out_data_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WORK = 3'b010,
    ST_LAST = 3'b100
  } bk_state_e;

  bk_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    top_q, top_d;
  logic          ovf_q, ovf_d;
  logic          rd_ok_q;
  q_item_t       cur_q, cur_d;
  logic          out_valid_q;
  out_beat_t     out_q;

  logic          out_load, can_pop, emit, emit_last;
  logic [7:0]    emit_char;
  logic          we;
  logic [CW-1:0] rd_full;
  logic [7:0]    rd_data;
  logic          empty, full;

  assign out_load = !out_valid_q || out_ready_i;
  assign can_pop  = (cnt_q == CW'(1)) || rd_ok_q;
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CW'(STACK_DEPTH));
  assign rd_full  = cnt_q - CW'(2);

  i2p_ram #(.Width(8), .Depth(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (cur_q.ch),
    .raddr_i (rd_full[IW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    top_d     = top_q;
    ovf_d     = ovf_q;
    cur_d     = cur_q;
    emit      = 1'b0;
    emit_char = top_q;
    emit_last = 1'b0;
    we        = 1'b0;
    q_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          cur_d   = q_item_i;
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        case (cur_q.kind)
          KIND_LITERAL: begin
            if (out_load) begin
              emit      = 1'b1;
              emit_char = cur_q.ch;
              state_d   = ST_LAST;
            end
          end
          KIND_LPAREN, KIND_OPER: begin
            if (cur_q.kind == KIND_OPER && !empty &&
                rank_of(top_q) >= rank_of(cur_q.ch)) begin
              if (can_pop && out_load) begin
                emit  = 1'b1;
                cnt_d = cnt_q - CW'(1);
                top_d = rd_data;
              end
            end else begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                we    = 1'b1;
                top_d = cur_q.ch;
                cnt_d = cnt_q + CW'(1);
              end
              state_d = ST_LAST;
            end
          end
          KIND_RPAREN: begin
            if (empty) begin
              state_d = ST_LAST;
            end else if (can_pop) begin
              if (top_q == CharLParen) begin
                cnt_d   = cnt_q - CW'(1);
                top_d   = rd_data;
                state_d = ST_LAST;
              end else if (out_load) begin
                emit  = 1'b1;
                cnt_d = cnt_q - CW'(1);
                top_d = rd_data;
              end
            end
          end
          default: state_d = ST_LAST;
        endcase
      end
      ST_LAST: begin
        if (!cur_q.last) begin
          state_d = ST_IDLE;
        end else if (!empty) begin
          if (can_pop && out_load) begin
            emit  = 1'b1;
            cnt_d = cnt_q - CW'(1);
            top_d = rd_data;
          end
        end else if (out_load) begin
          emit      = 1'b1;
          emit_char = CharNul;
          emit_last = 1'b1;
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    top_q <= top_d;
    if (emit) begin
      out_q.out_char      <= emit_char;
      out_q.last_out      <= emit_last;
      out_q.overflow_seen <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      rd_ok_q <= (cnt_d == cnt_q);
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- design/infix_to_postfix_converter_unit.sv -----
// Infix to postfix converter (shunting-yard) top level.
// Depends on i2p_pkg, i2p_front, i2p_back, i2p_ram and the assertion macros.
//
// Usage: one ASCII character per input beat on in_data_i, end_of_expr set on
// the last one. Output beats carry postfix characters; the expression ends
// with a beat of out_char 0 and last_out 1. overflow_seen shows that an
// operator push was dropped on a full stack earlier in the same expression.
// Both channels use valid/ready. A two-entry queue between the classifier and
// the stack sequencer holds up to two input beats while the output stalls;
// the sequencer holds while the output register is full and not taken.
// An accepted beat is registered in the queue and offered to the sequencer
// in the next cycle; there it passes the take, execute and end check states
// when it pops nothing. Each pop waits for the entry below the top to come
// from the stack RAM's registered read port. The final flush pops every
// stacked entry and then emits the terminator.
// Reset: empties the stack, clears the overflow flag and both channels; the
// stack RAM itself is not cleared.
`default_nettype none

`include "infix_to_postfix_converter_unit_macros.svh"

module infix_to_postfix_converter_unit import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_beat_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_beat_t     out_data_o
);

  logic    q_valid, q_ready, busy;
  q_item_t q_item;

  i2p_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  i2p_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `I2P_ASSERT_NOW(a_term_is_nul, out_valid_o && out_data_o.last_out, out_data_o.out_char == 8'h00, "terminator beat carries a nonzero character")
  `I2P_ASSERT_NOW(a_take_when_idle, q_ready, !busy, "queue read while sequencer busy")
  `I2P_ASSERT_NEXT(a_take_starts_work, q_valid && q_ready, busy, "queue item taken but sequencer idle")

endmodule

`default_nettype wire

// ----- bench/infix_to_postfix_converter_unit_test.sv -----
// Testbench for infix_to_postfix_converter_unit: directed table, then random expressions.
// Expected beats: typed table rows, else a shunting-yard predictor here. Needs i2p_pkg.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_test;
  import i2p_pkg::*;

  localparam int StackDepth = 32;
  localparam int RandomChars = 140;
  localparam out_beat_t NoBeat = '0;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoe;
    logic       typed;
    logic [1:0] n_typed;
    out_beat_t  w0;
    out_beat_t  w1;
  } script_row_t;

  localparam int ScriptLen = 23;
  localparam script_row_t Script [ScriptLen] = '{
    '{"a",       1'b0, 1'b1, 2'd1, '{"a", 1'b0, 1'b0},      NoBeat},
    '{CharNul,   1'b0, 1'b1, 2'd1, '{CharNul, 1'b0, 1'b0},  NoBeat},
    '{8'hFF,     1'b0, 1'b1, 2'd1, '{8'hFF, 1'b0, 1'b0},    NoBeat},
    '{CharSpace, 1'b0, 1'b1, 2'd0, NoBeat,                  NoBeat},
    '{CharTab,   1'b0, 1'b1, 2'd0, NoBeat,                  NoBeat},
    '{CharLParen, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{"b",        1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharPlus,   1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{"c",        1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharStar,   1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{"d",        1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharRParen, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharCaret,  1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{"e",        1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharCaret,  1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharMinus,  1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharSlash,  1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharRParen, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharLParen, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{"f",        1'b1, 1'b0, 2'd0, NoBeat, NoBeat},
    '{CharNul,   1'b1, 1'b1, 2'd2, '{CharNul, 1'b0, 1'b0}, '{CharNul, 1'b1, 1'b0}},
    '{8'hFF,     1'b1, 1'b1, 2'd2, '{8'hFF, 1'b0, 1'b0},   '{CharNul, 1'b1, 1'b0}},
    '{CharSpace, 1'b1, 1'b1, 2'd1, '{CharNul, 1'b1, 1'b0}, NoBeat}
  };

  localparam logic [7:0] OperSet [5] = '{CharPlus, CharMinus, CharStar, CharSlash, CharCaret};
  localparam logic [7:0] SpecialSet [10] = '{CharPlus, CharMinus, CharStar, CharSlash,
                                             CharCaret, CharLParen, CharRParen, CharSpace,
                                             CharTab, CharNul};

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  logic [7:0] opstk [StackDepth];
  int         depth_cnt;
  logic       ovf_pend;
  out_beat_t  released [$];
  out_beat_t  postfix_q [$];
  in_beat_t   expr_q [$];
  int         calm_left [2];
  int         errors;

  infix_to_postfix_converter_unit #(.STACK_DEPTH(StackDepth)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [1:0] prec(logic [7:0] c);
    if (c == CharCaret) return 2'd3;
    if (c == CharStar || c == CharSlash) return 2'd2;
    if (c == CharPlus || c == CharMinus) return 2'd1;
    return 2'd0;
  endfunction

  function automatic void emit_char(logic [7:0] c, logic fin);
    out_beat_t b;
    b.out_char = c;
    b.last_out = fin;
    b.overflow_seen = ovf_pend;
    released.push_back(b);
  endfunction

  function automatic void push_oper(logic [7:0] c);
    if (depth_cnt >= StackDepth) begin
      ovf_pend = 1'b1;
    end else begin
      opstk[depth_cnt] = c;
      depth_cnt++;
    end
  endfunction

  function automatic void shunt(in_beat_t b);
    logic [7:0] top;
    logic [1:0] r;
    logic       found;
    released.delete();
    case (b.in_char)
      CharSpace, CharTab: begin
      end
      CharLParen: begin
        push_oper(CharLParen);
      end
      CharRParen: begin
        found = 1'b0;
        while (depth_cnt > 0 && !found) begin
          depth_cnt--;
          top = opstk[depth_cnt];
          if (top == CharLParen) found = 1'b1;
          else emit_char(top, 1'b0);
        end
      end
      CharPlus, CharMinus, CharStar, CharSlash, CharCaret: begin
        r = prec(b.in_char);
        while (depth_cnt > 0 && prec(opstk[depth_cnt-1]) >= r) begin
          depth_cnt--;
          emit_char(opstk[depth_cnt], 1'b0);
        end
        push_oper(b.in_char);
      end
      default: begin
        emit_char(b.in_char, 1'b0);
      end
    endcase
    if (b.end_of_expr) begin
      while (depth_cnt > 0) begin
        depth_cnt--;
        emit_char(opstk[depth_cnt], 1'b0);
      end
      emit_char(CharNul, 1'b1);
      ovf_pend = 1'b0;
    end
  endfunction

  // side 0 = sender, side 1 = receiver; occasional runs of zero wait
  function automatic int pick_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_beat(in_beat_t b, logic use_pred);
    int gap;
    gap = pick_wait(0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    shunt(b);
    if (use_pred) begin
      foreach (released[i]) postfix_q.push_back(released[i]);
    end
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_char(logic [7:0] c, logic blanks);
    in_beat_t b;
    if (blanks && $urandom_range(0, 7) == 0) begin
      b.in_char = $urandom_range(0, 1) ? CharSpace : CharTab;
      b.end_of_expr = 1'b0;
      expr_q.push_back(b);
    end
    b.in_char = c;
    b.end_of_expr = 1'b0;
    expr_q.push_back(b);
  endfunction

  function automatic logic [7:0] pick_operand();
    if ($urandom_range(0, 1)) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic void close_expr();
    in_beat_t b;
    b = expr_q.pop_back();
    b.end_of_expr = 1'b1;
    expr_q.push_back(b);
  endfunction

  function automatic void gen_formula();
    int terms;
    int depth;
    expr_q.delete();
    depth = 0;
    terms = $urandom_range(1, 8);
    for (int t = 0; t < terms; t++) begin
      while (depth < 6 && $urandom_range(0, 3) == 0) begin
        add_char(CharLParen, 1'b1);
        depth++;
      end
      add_char(pick_operand(), 1'b1);
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        add_char(CharRParen, 1'b1);
        depth--;
      end
      if (t < terms - 1) add_char(OperSet[$urandom_range(0, 4)], 1'b1);
    end
    while (depth > 0) begin
      add_char(CharRParen, 1'b1);
      depth--;
    end
    close_expr();
  endfunction

  // deep nesting that pushes against the stack limit
  function automatic void gen_deep(logic all_parens);
    int n;
    int r;
    expr_q.delete();
    n = all_parens ? 36 : $urandom_range(34, 44);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (all_parens || r < 8) add_char(CharLParen, 1'b0);
      else if (r == 8) add_char(pick_operand(), 1'b0);
      else add_char(OperSet[$urandom_range(0, 4)], 1'b0);
    end
    add_char(pick_operand(), 1'b0);
    close_expr();
  endfunction

  function automatic void gen_noise();
    int n;
    expr_q.delete();
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) add_char(SpecialSet[$urandom_range(0, 9)], 1'b0);
      else add_char(8'($urandom_range(0, 255)), 1'b0);
    end
    close_expr();
  endfunction

  initial begin : stimulus
    in_beat_t b;
    int       counted;
    int       pick;
    logic     paused;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    depth_cnt = 0;
    ovf_pend = 1'b0;
    calm_left[0] = 0;
    calm_left[1] = 0;
    errors = 0;
    counted = 0;
    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (Script[i]) begin
      b.in_char = Script[i].ch;
      b.end_of_expr = Script[i].eoe;
      send_beat(b, !Script[i].typed);
      if (Script[i].typed) begin
        if (Script[i].n_typed > 0) postfix_q.push_back(Script[i].w0);
        if (Script[i].n_typed > 1) postfix_q.push_back(Script[i].w1);
      end
    end
    drain_wait();

    gen_deep(1'b1);
    while (counted < RandomChars) begin
      foreach (expr_q[i]) begin
        send_beat(expr_q[i], 1'b1);
        if (expr_q[i].in_char != CharSpace && expr_q[i].in_char != CharTab) counted++;
      end
      if (!paused && counted > RandomChars / 2) begin
        drain_wait();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) gen_deep(1'b0);
      else if (pick < 80) gen_formula();
      else gen_noise();
    end

    drain_wait();
    repeat (120) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : receiver
    out_beat_t want;
    int        stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pick_wait(1);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (postfix_q.size() == 0) begin
        flag_mismatch("beat with nothing expected, out_char", int'(out_data_o.out_char), 0);
      end else begin
        want = postfix_q.pop_front();
        if (out_data_o.out_char !== want.out_char)
          flag_mismatch("out_char", int'(out_data_o.out_char), int'(want.out_char));
        if (out_data_o.last_out !== want.last_out)
          flag_mismatch("last_out", int'(out_data_o.last_out), int'(want.last_out));
        if (out_data_o.overflow_seen !== want.overflow_seen)
          flag_mismatch("overflow_seen", int'(out_data_o.overflow_seen),
                        int'(want.overflow_seen));
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
